/* design/lps_pkg.sv */
`default_nettype none
package lps_pkg;

  localparam int NUM_SLOTS   = 64;
  localparam int NUM_QUEUES  = 16;
  localparam int TICKET_BITS = 16;

  localparam int IDX_W     = $clog2(NUM_SLOTS);
  localparam int CNT_W     = $clog2(NUM_SLOTS + 1);
  localparam int PRIO_W    = 4;
  localparam int TOTAL_W   = 22;
  localparam int SUM_W     = ((TICKET_BITS > TOTAL_W) ? TICKET_BITS : TOTAL_W) + 1;
  localparam int RND_W     = 31;
  localparam int DIV_CNT_W = $clog2(RND_W);
  localparam int CFG_IDX_W = 2;

  localparam logic [TICKET_BITS-1:0] TICKET_MAX = '1;
  localparam logic [TOTAL_W-1:0]     TOTAL_MAX  = '1;

  // Event codes
  localparam logic [2:0] FUNC_START   = 3'd0;
  localparam logic [2:0] FUNC_STOP    = 3'd1;
  localparam logic [2:0] FUNC_NICE    = 3'd2;
  localparam logic [2:0] FUNC_EXPIRE  = 3'd3;
  localparam logic [2:0] FUNC_BALANCE = 3'd4;

  // Result status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_SLOT = 2'd1;
  localparam logic [1:0] ST_BAD_PRIO = 2'd2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_USER_QUEUE   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOP_QUEUE    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOTTOM_QUEUE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BASE_TICKETS = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE, S_READ, S_EXEC, S_SUM, S_DIV, S_PICK, S_BAL, S_DONE
  } state_e;

  typedef struct packed {
    logic [PRIO_W-1:0]      prio;
    logic [PRIO_W-1:0]      max_prio;
    logic [TICKET_BITS-1:0] tickets;
  } entry_t;

  typedef struct packed {
    logic capture;
    logic read_slot;
    logic exec;
    logic sum_step;
    logic div_init;
    logic div_step;
    logic walk_clr;
    logic pick_step;
    logic bal_step;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic exec_lottery;
    logic exec_balance;
    logic walk_done;
    logic sum_zero;
    logic div_done;
    logic out_full;
  } stat_t;

endpackage
`default_nettype wire

/* design/lps_if.sv */
`default_nettype none
interface lps_evt_if;
  logic              valid;
  logic              ready;
  logic [2:0]        func;
  logic [5:0]        slot;
  logic [5:0]        parent_slot;
  logic              start_kind;
  logic [4:0]        max_prio;
  logic signed [7:0] ticket_delta;
  logic [30:0]       random_value;
  modport source (output valid, func, slot, parent_slot, start_kind, max_prio,
                  ticket_delta, random_value, input ready);
  modport sink (input valid, func, slot, parent_slot, start_kind, max_prio,
                ticket_delta, random_value, output ready);
endinterface

interface lps_res_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        lottery_ran;
  logic        winner_found;
  logic [5:0]  winner_slot;
  logic [21:0] total_tickets;
  modport source (output valid, status, lottery_ran, winner_found, winner_slot,
                  total_tickets, input ready);
  modport sink (input valid, status, lottery_ran, winner_found, winner_slot,
                total_tickets, output ready);
endinterface

interface lps_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] index;
  logic [7:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* design/lps_ctrl.sv */
`default_nettype none
module lps_ctrl (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire                   evt_valid_i,
  output logic                  evt_ready_o,
  input  wire                   out_ready_i,
  input  wire lps_pkg::stat_t   stat_i,
  output lps_pkg::cmd_t         cmd_o
);

  lps_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= lps_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    evt_ready_o = 1'b0;
    case (state_q)
      lps_pkg::S_IDLE: begin
        evt_ready_o = 1'b1;
        if (evt_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = lps_pkg::S_READ;
        end
      end
      lps_pkg::S_READ: begin
        cmd_o.read_slot = 1'b1;
        state_d         = lps_pkg::S_EXEC;
      end
      lps_pkg::S_EXEC: begin
        cmd_o.exec     = 1'b1;
        cmd_o.walk_clr = 1'b1;
        if (stat_i.exec_lottery) state_d = lps_pkg::S_SUM;
        else if (stat_i.exec_balance) state_d = lps_pkg::S_BAL;
        else state_d = lps_pkg::S_DONE;
      end
      lps_pkg::S_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (stat_i.walk_done) begin
          cmd_o.div_init = 1'b1;
          state_d        = lps_pkg::S_DIV;
        end
      end
      lps_pkg::S_DIV: begin
        if (stat_i.sum_zero) begin
          state_d = lps_pkg::S_DONE;
        end else begin
          cmd_o.div_step = 1'b1;
          if (stat_i.div_done) begin
            cmd_o.walk_clr = 1'b1;
            state_d        = lps_pkg::S_PICK;
          end
        end
      end
      lps_pkg::S_PICK: begin
        cmd_o.pick_step = 1'b1;
        if (stat_i.walk_done) state_d = lps_pkg::S_DONE;
      end
      lps_pkg::S_BAL: begin
        cmd_o.bal_step = 1'b1;
        if (stat_i.walk_done) state_d = lps_pkg::S_DONE;
      end
      lps_pkg::S_DONE: begin
        if (!stat_i.out_full || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = lps_pkg::S_IDLE;
        end
      end
      default: state_d = lps_pkg::S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* design/lps_datapath.sv */
`default_nettype none
module lps_datapath (
  input  wire                   clk_i,
  input  wire                   rst_ni,
  input  wire lps_pkg::cmd_t    cmd_i,
  output lps_pkg::stat_t        stat_o,
  input  wire [2:0]             func_i,
  input  wire [5:0]             slot_i,
  input  wire [5:0]             parent_slot_i,
  input  wire                   start_kind_i,
  input  wire [4:0]             max_prio_i,
  input  wire signed [7:0]      ticket_delta_i,
  input  wire [30:0]            random_value_i,
  input  wire                   cfg_we_i,
  input  wire [1:0]             cfg_index_i,
  input  wire [7:0]             cfg_data_i,
  input  wire                   out_ready_i,
  output logic                  out_valid_o,
  output logic [1:0]            status_o,
  output logic                  lottery_ran_o,
  output logic                  winner_found_o,
  output logic [5:0]            winner_slot_o,
  output logic [21:0]           total_tickets_o
);

  localparam int TW = lps_pkg::TICKET_BITS + 2;

  // Configuration
  logic [3:0] uq_q, top_q, bot_q;
  logic [7:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      uq_q   <= 4'd13;
      top_q  <= 4'd12;
      bot_q  <= 4'd15;
      base_q <= 8'd5;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        lps_pkg::REG_USER_QUEUE:   uq_q   <= cfg_data_i[3:0];
        lps_pkg::REG_TOP_QUEUE:    top_q  <= cfg_data_i[3:0];
        lps_pkg::REG_BOTTOM_QUEUE: bot_q  <= cfg_data_i[3:0];
        lps_pkg::REG_BASE_TICKETS: base_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Captured event word
  logic [2:0]        func_q;
  logic [5:0]        slot_q, pslot_q;
  logic              kind_q;
  logic [4:0]        mp_q;
  logic signed [7:0] delta_q;
  logic [30:0]       rnd_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      func_q  <= func_i;
      slot_q  <= slot_i;
      pslot_q <= parent_slot_i;
      kind_q  <= start_kind_i;
      mp_q    <= max_prio_i;
      delta_q <= ticket_delta_i;
      rnd_q   <= random_value_i;
    end
  end

  logic                      slot_in, pslot_in;
  logic [lps_pkg::IDX_W-1:0] sidx, pidx;
  assign slot_in  = 32'(slot_q) < lps_pkg::NUM_SLOTS;
  assign pslot_in = 32'(pslot_q) < lps_pkg::NUM_SLOTS;
  assign sidx     = slot_in ? lps_pkg::IDX_W'(slot_q) : '0;
  assign pidx     = pslot_in ? lps_pkg::IDX_W'(pslot_q) : '0;

  // Slot table: in-use flags in flops, the rest in a memory
  logic [lps_pkg::NUM_SLOTS-1:0] active_q, active_d;
  lps_pkg::entry_t mem [lps_pkg::NUM_SLOTS];
  lps_pkg::entry_t rdata_q, wdata;
  logic [lps_pkg::IDX_W-1:0] raddr, waddr;
  logic we;

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wdata;
    rdata_q <= mem[raddr];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) active_q <= '0;
    else active_q <= active_d;
  end

  // Walk counter: issue address cnt, process entry cnt-1
  logic [lps_pkg::CNT_W-1:0] cnt_q;
  logic [lps_pkg::IDX_W-1:0] pidx_w;
  logic                      proc_v, walk_done;
  assign walk_done = 32'(cnt_q) == lps_pkg::NUM_SLOTS;
  assign proc_v    = cnt_q != '0;
  assign pidx_w    = lps_pkg::IDX_W'(cnt_q - 1'b1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.walk_clr) begin
      cnt_q <= '0;
    end else if ((cmd_i.sum_step || cmd_i.pick_step || cmd_i.bal_step) && !walk_done) begin
      cnt_q <= cnt_q + 1'b1;
    end
  end

  always_comb begin
    if (cmd_i.read_slot) raddr = sidx;
    else if (!walk_done) raddr = lps_pkg::IDX_W'(cnt_q);
    else raddr = '0;
  end

  function automatic logic in_user(input logic [3:0] p, input logic [3:0] top,
                                   input logic [3:0] bot);
    in_user = (p >= top) && (p <= bot);
  endfunction

  logic elig;
  assign elig = active_q[pidx_w] && in_user(rdata_q.prio, top_q, bot_q) &&
                (rdata_q.prio == uq_q);

  // Result fields being built
  logic [1:0]               res_status_q, res_status_d;
  logic                     res_ran_q, res_ran_d;
  logic                     found_q, found_d;
  logic [5:0]               win_q, win_d;
  logic [lps_pkg::TOTAL_W-1:0] total_q, total_d;
  logic [lps_pkg::SUM_W-1:0]   acc_q, acc_d, acc_sum, tot_sum;
  logic                     exec_lottery, exec_balance;

  // Remainder unit, one quotient bit per cycle
  logic [lps_pkg::TOTAL_W-1:0]   rem_q;
  logic [lps_pkg::TOTAL_W:0]     rem_sh;
  logic [30:0]                   sh_q;
  logic [lps_pkg::DIV_CNT_W-1:0] dcnt_q;
  logic                          div_done;
  assign rem_sh   = {rem_q, sh_q[30]};
  assign div_done = 32'(dcnt_q) == lps_pkg::RND_W - 1;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      rem_q  <= '0;
      sh_q   <= rnd_q;
      dcnt_q <= '0;
    end else if (cmd_i.div_step) begin
      rem_q  <= (rem_sh >= {1'b0, total_q}) ?
                lps_pkg::TOTAL_W'(rem_sh - {1'b0, total_q}) :
                lps_pkg::TOTAL_W'(rem_sh);
      sh_q   <= {sh_q[29:0], 1'b0};
      dcnt_q <= dcnt_q + 1'b1;
    end
  end

  logic signed [TW-1:0] nice_t;
  logic [lps_pkg::TICKET_BITS-1:0] nice_tk;
  logic [4:0] p_inc;
  assign nice_t = signed'({2'b00, rdata_q.tickets}) + TW'(delta_q);
  assign p_inc  = {1'b0, rdata_q.prio} + 5'd1;

  always_comb begin
    if (nice_t < signed'(TW'(base_q))) nice_tk = lps_pkg::TICKET_BITS'(base_q);
    else if (nice_t > signed'({2'b00, lps_pkg::TICKET_MAX})) nice_tk = lps_pkg::TICKET_MAX;
    else nice_tk = lps_pkg::TICKET_BITS'(nice_t);
  end

  assign tot_sum = lps_pkg::SUM_W'(total_q) + lps_pkg::SUM_W'(rdata_q.tickets);
  assign acc_sum = acc_q + lps_pkg::SUM_W'(rdata_q.tickets);

  always_comb begin
    active_d     = active_q;
    we           = 1'b0;
    waddr        = sidx;
    wdata        = rdata_q;
    res_status_d = res_status_q;
    res_ran_d    = res_ran_q;
    found_d      = found_q;
    win_d        = win_q;
    total_d      = total_q;
    acc_d        = acc_q;
    exec_lottery = 1'b0;
    exec_balance = 1'b0;

    if (cmd_i.exec) begin
      res_status_d = lps_pkg::ST_OK;
      res_ran_d    = 1'b0;
      found_d      = 1'b0;
      win_d        = '0;
      total_d      = '0;
      if (func_q == lps_pkg::FUNC_START) begin
        if (!slot_in || active_q[sidx]) begin
          res_status_d = lps_pkg::ST_BAD_SLOT;
        end else if (32'(mp_q) >= lps_pkg::NUM_QUEUES) begin
          res_status_d = lps_pkg::ST_BAD_PRIO;
        end else if (kind_q && (!pslot_in || !active_q[pidx])) begin
          res_status_d = lps_pkg::ST_BAD_SLOT;
        end else begin
          we             = 1'b1;
          wdata.max_prio = mp_q[3:0];
          wdata.prio     = kind_q ? uq_q : mp_q[3:0];
          wdata.tickets  = lps_pkg::TICKET_BITS'(base_q);
          active_d[sidx] = 1'b1;
        end
      end else if (func_q == lps_pkg::FUNC_BALANCE) begin
        exec_balance = 1'b1;
      end else if (func_q > lps_pkg::FUNC_BALANCE) begin
        res_status_d = lps_pkg::ST_OK;
      end else if (!slot_in || !active_q[sidx]) begin
        res_status_d = lps_pkg::ST_BAD_SLOT;
      end else begin
        exec_lottery = 1'b1;
        res_ran_d    = 1'b1;
        case (func_q)
          lps_pkg::FUNC_STOP: active_d[sidx] = 1'b0;
          lps_pkg::FUNC_NICE: begin
            we            = 1'b1;
            wdata.tickets = nice_tk;
            wdata.prio    = uq_q;
          end
          default: begin
            we = 1'b1;
            if (in_user(rdata_q.prio, top_q, bot_q)) wdata.prio = uq_q;
            else if (p_inc < {1'b0, top_q}) wdata.prio = p_inc[3:0];
          end
        endcase
      end
    end

    if (cmd_i.walk_clr) acc_d = '0;

    if (cmd_i.sum_step && proc_v && elig) begin
      total_d = (tot_sum > lps_pkg::SUM_W'(lps_pkg::TOTAL_MAX)) ?
                lps_pkg::TOTAL_MAX : lps_pkg::TOTAL_W'(tot_sum);
    end

    if (cmd_i.pick_step && proc_v && elig && !found_q) begin
      acc_d = acc_sum;
      if (acc_sum > lps_pkg::SUM_W'(rem_q)) begin
        found_d    = 1'b1;
        win_d      = 6'(pidx_w);
        we         = 1'b1;
        waddr      = pidx_w;
        wdata.prio = top_q;
      end
    end

    if (cmd_i.bal_step && proc_v && active_q[pidx_w] &&
        rdata_q.prio > rdata_q.max_prio && !in_user(rdata_q.prio, top_q, bot_q)) begin
      we         = 1'b1;
      waddr      = pidx_w;
      wdata.prio = rdata_q.prio - 4'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    res_status_q <= res_status_d;
    res_ran_q    <= res_ran_d;
    found_q      <= found_d;
    win_q        <= win_d;
    total_q      <= total_d;
    acc_q        <= acc_d;
  end

  // Output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (cmd_i.load_out) out_valid_q <= 1'b1;
    else if (out_ready_i) out_valid_q <= 1'b0;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      status_o        <= res_status_q;
      lottery_ran_o   <= res_ran_q;
      winner_found_o  <= found_q;
      winner_slot_o   <= win_q;
      total_tickets_o <= total_q;
    end
  end

  assign out_valid_o = out_valid_q;

  assign stat_o.exec_lottery = exec_lottery;
  assign stat_o.exec_balance = exec_balance;
  assign stat_o.walk_done    = walk_done;
  assign stat_o.sum_zero     = total_q == '0;
  assign stat_o.div_done     = div_done;
  assign stat_o.out_full     = out_valid_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(cnt_q) <= lps_pkg::NUM_SLOTS)
    else $error("walk counter past table end");

  a_rem_below: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |-> (rem_q < total_q))
    else $error("remainder not below ticket sum");

  a_win_ran: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_out && found_q |-> res_ran_q && (total_q != '0))
    else $error("winner without lottery");

endmodule
`default_nettype wire

/* design/lottery_process_scheduler.sv */
`default_nettype none
// Lottery process scheduler. Holds a 64-slot process table (in-use flag,
// priority, maximum priority, ticket count) and handles one event word at a
// time: start, stop, nice, quantum expiry and balance tick, each answered by
// one result word. Stop, nice and expiry then run a lottery: one walk over
// the table sums the tickets of slots waiting at user_queue, a one-bit-per-
// cycle remainder unit reduces random_value modulo that sum, and a second
// walk picks the winner and raises it to top_user_queue. Each walk reads the
// slot memory at one entry per cycle. A new event is taken only after the
// previous result is in the output register. Configuration writes are taken
// at any time and must be made while the block is idle.
module lottery_process_scheduler (
  input  wire        clk_i,
  input  wire        rst_ni,
  lps_evt_if.sink    evt_i,
  lps_res_if.source  res_o,
  lps_cfg_if.sink    cfg_i
);

  lps_pkg::cmd_t  cmd;
  lps_pkg::stat_t stat;

  // Registers accept a word every cycle
  assign cfg_i.ready = 1'b1;

  lps_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .evt_valid_i (evt_i.valid),
    .evt_ready_o (evt_i.ready),
    .out_ready_i (res_o.ready),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  lps_datapath u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .func_i          (evt_i.func),
    .slot_i          (evt_i.slot),
    .parent_slot_i   (evt_i.parent_slot),
    .start_kind_i    (evt_i.start_kind),
    .max_prio_i      (evt_i.max_prio),
    .ticket_delta_i  (evt_i.ticket_delta),
    .random_value_i  (evt_i.random_value),
    .cfg_we_i        (cfg_i.valid),
    .cfg_index_i     (cfg_i.index),
    .cfg_data_i      (cfg_i.data),
    .out_ready_i     (res_o.ready),
    .out_valid_o     (res_o.valid),
    .status_o        (res_o.status),
    .lottery_ran_o   (res_o.lottery_ran),
    .winner_found_o  (res_o.winner_found),
    .winner_slot_o   (res_o.winner_slot),
    .total_tickets_o (res_o.total_tickets)
  );

endmodule
`default_nettype wire
